@@ hdl/pidsha_pkg.sv @@
// Shared types, constants and SHA-256 helper functions for the process id UUID hasher.
// Used by pidsha_ctrl, pidsha_dp and process_id_sha256_uuidv8; depends on nothing else.
`timescale 1ns / 1ps

package pidsha_pkg;

  // Input beat: one process event.
  typedef struct packed {
    logic [63:0] process_start_time;
    logic [63:0] process_number;
  } pidsha_in_t;

  // Result beat: the four UUID fields.
  typedef struct packed {
    logic [31:0] uuid_time_low;
    logic [15:0] uuid_mid;
    logic [15:0] uuid_hi_version;
    logic [63:0] uuid_tail;
  } pidsha_out_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GUID_HIGH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GUID_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_TIME = 2'd2;

  // Round counting.
  localparam int ROUNDS  = 64;
  localparam int ROUND_W = 6;
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

  // Padding words for a 320-bit message in one block.
  localparam logic [31:0] PAD_MARKER  = 32'h8000_0000;
  localparam logic [31:0] MSG_BIT_LEN = 32'd320;

  // UUID version and variant marks.
  localparam logic [3:0] UUID_VERSION = 4'h8;
  localparam logic [1:0] UUID_VARIANT = 2'b10;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               load;      // start a new block from the input beat
    logic               round_en;  // run one compression round
    logic [ROUND_W-1:0] round;     // index of that round
    logic               out_load;  // capture the finished UUID
  } pidsha_cmd_t;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INITIAL_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Byte reversal of a 32-bit word.
  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

@@ hdl/pidsha_ctrl.sv @@
// Controller for the process id UUID hasher: sequences load, 64 rounds and result hand-off.
// Depends on pidsha_pkg for the state type and the command struct.
`timescale 1ns / 1ps

module pidsha_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output pidsha_pkg::pidsha_cmd_t  cmd
);
  import pidsha_pkg::*;

  ctrl_state_t        state_r, state_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic               out_valid_r, out_valid_nxt;

  // State, round counter and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    round_nxt    = round_r;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.round_en = 1'b0;
    cmd.round    = round_r;
    cmd.out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          round_nxt = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (round_r == LAST_ROUND) begin
          round_nxt = '0;
          state_nxt = ST_DONE;
        end else begin
          round_nxt = round_r + 1'b1;
        end
      end
      ST_DONE: begin
        // The result register is free, or its beat leaves this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid follows the output register.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // A new block always starts at round zero.
  a_load_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_ROUND && round_r == '0))
    else $error("block load did not start the rounds at zero");

  // Rounds advance one per cycle until the last.
  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && round_r != LAST_ROUND) |=>
      (state_r == ST_ROUND && round_r == $past(round_r) + 1'b1))
    else $error("round counter skipped or stopped");

  // A result only appears after the final round has completed.
  a_result_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result valid raised outside the finish state");

  // No input is taken while a block is being hashed.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> !cmd.load && !cmd.out_load)
    else $error("load or result capture during rounds");
`endif

endmodule

@@ hdl/pidsha_dp.sv @@
// Datapath of the process id UUID hasher: configuration registers, message schedule,
// SHA-256 round logic and the result register. Depends on pidsha_pkg.
`timescale 1ns / 1ps

module pidsha_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [pidsha_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                         cfg_data,
  input  pidsha_pkg::pidsha_in_t              in_data,
  input  pidsha_pkg::pidsha_cmd_t             cmd,
  output pidsha_pkg::pidsha_out_t             out_data
);
  import pidsha_pkg::*;

  logic [63:0] guid_high_r;
  logic [63:0] guid_low_r;
  logic [63:0] sys_time_r;

  logic [31:0] vars_r  [8];
  logic [31:0] sched_r [16];
  logic [31:0] msg     [16];

  logic [31:0] new_w;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] h0, h1, h2, h3;

  pidsha_out_t out_data_r;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guid_high_r <= '0;
      guid_low_r  <= '0;
      sys_time_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GUID_HIGH:   guid_high_r <= cfg_data;
        CFG_GUID_LOW:    guid_low_r  <= cfg_data;
        CFG_SYSTEM_TIME: sys_time_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Padded message block as big-endian words.
  always_comb begin
    msg[0]  = bswap32(guid_high_r[63:32]);
    msg[1]  = {guid_high_r[23:16], guid_high_r[31:24], guid_high_r[7:0], guid_high_r[15:8]};
    msg[2]  = guid_low_r[63:32];
    msg[3]  = guid_low_r[31:0];
    msg[4]  = bswap32(sys_time_r[31:0]);
    msg[5]  = bswap32(sys_time_r[63:32]);
    msg[6]  = bswap32(in_data.process_start_time[31:0]);
    msg[7]  = bswap32(in_data.process_start_time[63:32]);
    msg[8]  = bswap32(in_data.process_number[31:0]);
    msg[9]  = bswap32(in_data.process_number[63:32]);
    msg[10] = PAD_MARKER;
    msg[11] = '0;
    msg[12] = '0;
    msg[13] = '0;
    msg[14] = '0;
    msg[15] = MSG_BIT_LEN;
  end

  // Schedule word sixteen rounds ahead, and the round function.
  always_comb begin
    new_w = small_sigma1(sched_r[14]) + sched_r[9] + small_sigma0(sched_r[1]) + sched_r[0];
    ch    = (vars_r[4] & vars_r[5]) ^ (~vars_r[4] & vars_r[6]);
    maj   = (vars_r[0] & vars_r[1]) ^ (vars_r[0] & vars_r[2]) ^ (vars_r[1] & vars_r[2]);
    t1    = vars_r[7] + big_sigma1(vars_r[4]) + ch + ROUND_K[cmd.round] + sched_r[0];
    t2    = big_sigma0(vars_r[0]) + maj;
  end

  // The schedule is a shift line: the word for the current round sits at the head.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 16; i++) begin
        sched_r[i] <= msg[i];
      end
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[15] <= new_w;
    end
  end

  // Working variables a..h, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        vars_r[i] <= '0;
      end
    end else if (cmd.load) begin
      for (int i = 0; i < 8; i++) begin
        vars_r[i] <= INITIAL_H[i];
      end
    end else if (cmd.round_en) begin
      vars_r[7] <= vars_r[6];
      vars_r[6] <= vars_r[5];
      vars_r[5] <= vars_r[4];
      vars_r[4] <= vars_r[3] + t1;
      vars_r[3] <= vars_r[2];
      vars_r[2] <= vars_r[1];
      vars_r[1] <= vars_r[0];
      vars_r[0] <= t1 + t2;
    end
  end

  // First four digest words; the UUID only needs digest bytes 0 to 15.
  always_comb begin
    h0 = INITIAL_H[0] + vars_r[0];
    h1 = INITIAL_H[1] + vars_r[1];
    h2 = INITIAL_H[2] + vars_r[2];
    h3 = INITIAL_H[3] + vars_r[3];
  end

  // Result register with version and variant marks applied.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.uuid_time_low   <= bswap32(h0);
      out_data_r.uuid_mid        <= {h1[23:16], h1[31:24]};
      out_data_r.uuid_hi_version <= {UUID_VERSION, h1[3:0], h1[15:8]};
      out_data_r.uuid_tail       <= {UUID_VARIANT, h2[29:0], h3};
    end
  end

  assign out_data = out_data_r;

endmodule

@@ hdl/process_id_sha256_uuidv8.sv @@
// Top level of the process id UUID hasher: joins the controller and the datapath.
// Depends on pidsha_pkg, pidsha_ctrl and pidsha_dp.
`timescale 1ns / 1ps

// Derives a version-8 UUID from the configured machine GUID and system start time plus
// each input beat's process start time and process number, by one SHA-256 compression
// of the padded 40-byte message. The block is loaded at the accepting edge, then the
// single round unit runs the rounds one after another, and the finish state adds the
// initial hash and fills the result register once that register is free. A new beat is
// accepted only when the previous item has reached the result register, which may still
// be waiting for the consumer. Configuration writes are always accepted and should be
// made while idle.
module process_id_sha256_uuidv8 (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pidsha_pkg::pidsha_in_t             in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pidsha_pkg::pidsha_out_t            out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pidsha_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                        cfg_data
);
  import pidsha_pkg::*;

  pidsha_cmd_t cmd;

  // Register writes are always accepted and never stall.
  assign cfg_ready = 1'b1;

  pidsha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pidsha_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

@@ test/tb_process_id_sha256_uuidv8.sv @@
// Testbench for process_id_sha256_uuidv8: streams process events and configuration writes
// with random idling and checks each UUID against its own SHA-256 prediction.
// Depends on pidsha_pkg and the process_id_sha256_uuidv8 RTL.
`timescale 1ns / 1ps

module tb_process_id_sha256_uuidv8;
  import pidsha_pkg::*;

  // Register index that maps to nothing; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 2'd3;

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 179;
  localparam int DRAIN_CYCLES    = 70;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_PRINTED     = 40;

  // Message padding and UUID marks.
  localparam logic [7:0]  PAD_BYTE       = 8'h80;
  localparam logic [15:0] MSG_BITS       = 16'd320;
  localparam logic [3:0]  VERSION_NIBBLE = 4'h8;
  localparam logic [1:0]  VARIANT_BITS   = 2'b10;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          value;
  } cfg_write_t;

  // Clock, reset and the ports of the block.
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  pidsha_in_t           in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pidsha_out_t          out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data  = '0;

  // Stimulus queues and the expected UUIDs in arrival order.
  pidsha_in_t  event_queue [$];
  cfg_write_t  cfg_queue [$];
  pidsha_out_t uuid_expected [$];
  pidsha_out_t uuid_want;

  // Configuration as the block should hold it.
  logic [63:0] cur_guid_high;
  logic [63:0] cur_guid_low;
  logic [63:0] cur_system_time;

  // Idling control and bookkeeping.
  logic in_idle_on  = 1'b1;
  logic out_idle_on = 1'b1;
  int   in_gap;
  int   out_stall;
  int   out_beats;
  int   quiet_cycles;
  int   err_count = 0;

  process_id_sha256_uuidv8 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Builds the padded 40-byte message, runs one SHA-256 compression and folds the
  // first 16 digest bytes into a version-8 UUID.
  function automatic pidsha_out_t uuid_from_event(input logic [63:0] ghigh,
                                                  input logic [63:0] glow,
                                                  input logic [63:0] stime,
                                                  input pidsha_in_t  ev);
    logic [7:0]  msg [64];
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [7:0]  dg [32];
    logic [31:0] s0, s1, t1, t2, ch, mj, word;
    pidsha_out_t res;
    for (int i = 0; i < 64; i++) msg[i] = 8'h00;
    // GUID in memory order: Data1, Data2, Data3 little-endian, then Data4 as stored.
    for (int i = 0; i < 4; i++) msg[i] = ghigh[32 + 8 * i +: 8];
    msg[4] = ghigh[23:16];
    msg[5] = ghigh[31:24];
    msg[6] = ghigh[7:0];
    msg[7] = ghigh[15:8];
    for (int i = 0; i < 8; i++) begin
      msg[8 + i]  = glow[56 - 8 * i +: 8];
      msg[16 + i] = stime[8 * i +: 8];
      msg[24 + i] = ev.process_start_time[8 * i +: 8];
      msg[32 + i] = ev.process_number[8 * i +: 8];
    end
    msg[40] = PAD_BYTE;
    msg[62] = MSG_BITS[15:8];
    msg[63] = MSG_BITS[7:0];

    // Full message schedule.
    for (int i = 0; i < 16; i++)
      w[i] = {msg[4 * i], msg[4 * i + 1], msg[4 * i + 2], msg[4 * i + 3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end

    // Compression rounds.
    for (int i = 0; i < 8; i++) v[i] = SHA_IV[i];
    for (int t = 0; t < 64; t++) begin
      s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + SHA_K[t] + w[t];
      s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + mj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end

    // Digest bytes, then the version and variant marks.
    for (int i = 0; i < 8; i++) begin
      word = SHA_IV[i] + v[i];
      dg[4 * i]     = word[31:24];
      dg[4 * i + 1] = word[23:16];
      dg[4 * i + 2] = word[15:8];
      dg[4 * i + 3] = word[7:0];
    end
    dg[7] = {VERSION_NIBBLE, dg[7][3:0]};
    dg[8] = {VARIANT_BITS, dg[8][5:0]};

    res.uuid_time_low   = {dg[3], dg[2], dg[1], dg[0]};
    res.uuid_mid        = {dg[5], dg[4]};
    res.uuid_hi_version = {dg[7], dg[6]};
    res.uuid_tail       = {dg[8], dg[9], dg[10], dg[11], dg[12], dg[13], dg[14], dg[15]};
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 16);
    return $urandom_range(40, 150);
  endfunction

  // Field values weighted toward edges: zero, all ones, single set or cleared bits and small numbers.
  function automatic logic [63:0] rand_field();
    int unsigned pos;
    pos = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << pos;
      3: return ~(64'd1 << pos);
      4: return 64'($urandom_range(0, 4095));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_error(input string what);
    if (err_count < MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, what);
    err_count++;
  endtask

  task automatic add_event(input logic [63:0] start_time, input logic [63:0] number);
    pidsha_in_t ev;
    ev.process_start_time = start_time;
    ev.process_number     = number;
    event_queue.push_back(ev);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] value);
    cfg_write_t wr;
    wr.index = index;
    wr.value = value;
    cfg_queue.push_back(wr);
  endtask

  // Waits until every queued beat and configuration write has gone through and every expected UUID has arrived.
  task automatic wait_drained();
    do @(negedge clk);
    while (event_queue.size() != 0 || in_valid || uuid_expected.size() != 0 ||
           cfg_queue.size() != 0 || cfg_valid);
  endtask

  // Input driver: predicts each accepted event, then presents the next after a random gap while idling is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready)
        uuid_expected.push_back(uuid_from_event(cur_guid_high, cur_guid_low,
                                                cur_system_time, in_data));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (event_queue.size() != 0) begin
          in_data  <= event_queue.pop_front();
          in_valid <= 1'b1;
          in_gap   <= in_idle_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Configuration driver: tracks every accepted write in the expected register copy.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid       <= 1'b0;
      cur_guid_high   <= '0;
      cur_guid_low    <= '0;
      cur_system_time <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GUID_HIGH:   cur_guid_high   <= cfg_data;
          CFG_GUID_LOW:    cur_guid_low    <= cfg_data;
          CFG_SYSTEM_TIME: cur_system_time <= cfg_data;
          default: ;
        endcase
      end
      if (!cfg_valid || cfg_ready) begin
        if (cfg_queue.size() != 0) begin
          {cfg_index, cfg_data} <= cfg_queue.pop_front();
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted beat field by field and stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
      out_beats <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (uuid_expected.size() == 0) begin
          report_error($sformatf("result beat %0d arrived with no event pending", out_beats));
        end else begin
          uuid_want = uuid_expected.pop_front();
          if (out_data.uuid_time_low !== uuid_want.uuid_time_low)
            report_error($sformatf("beat %0d uuid_time_low %h, expected %h", out_beats,
                                   out_data.uuid_time_low, uuid_want.uuid_time_low));
          if (out_data.uuid_mid !== uuid_want.uuid_mid)
            report_error($sformatf("beat %0d uuid_mid %h, expected %h", out_beats,
                                   out_data.uuid_mid, uuid_want.uuid_mid));
          if (out_data.uuid_hi_version !== uuid_want.uuid_hi_version)
            report_error($sformatf("beat %0d uuid_hi_version %h, expected %h", out_beats,
                                   out_data.uuid_hi_version, uuid_want.uuid_hi_version));
          if (out_data.uuid_tail !== uuid_want.uuid_tail)
            report_error($sformatf("beat %0d uuid_tail %h, expected %h", out_beats,
                                   out_data.uuid_tail, uuid_want.uuid_tail));
        end
        out_beats <= out_beats + 1;
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no beat of any channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Test sequence: directed events under fixed settings, then random phases.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at their reset value of zero.
    add_event('0, '0);
    add_event('1, '1);
    add_event('1, '0);
    add_event('0, '1);
    add_event({16{4'hA}}, {16{4'h5}});
    add_event({16{4'h5}}, {16{4'hA}});
    add_event(64'd1, 64'h8000_0000_0000_0000);
    add_event(64'h8000_0000_0000_0000, 64'd1);
    add_event(64'h01d9_a3b4_c5d6_e7f8, 64'd4);
    wait_drained();

    // A write to the unmapped index must leave every register untouched.
    add_cfg(CFG_IDX_UNMAPPED, '1);
    wait_drained();
    add_event('0, '0);
    add_event('1, '1);
    wait_drained();

    // Every register at all ones.
    add_cfg(CFG_GUID_HIGH, '1);
    add_cfg(CFG_GUID_LOW, '1);
    add_cfg(CFG_SYSTEM_TIME, '1);
    wait_drained();
    add_event('0, '0);
    add_event('1, '1);
    add_event({16{4'hA}}, {16{4'h5}});
    wait_drained();

    // Distinct bytes everywhere, so any byte-order slip shows up.
    add_cfg(CFG_GUID_HIGH, 64'h0011_2233_4455_6677);
    add_cfg(CFG_GUID_LOW, 64'h8899_aabb_ccdd_eeff);
    add_cfg(CFG_SYSTEM_TIME, 64'h01d9_0102_0304_0506);
    wait_drained();
    add_event(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    add_event(64'h1020_3040_5060_7080, 64'd1234);
    add_event(64'hffff_0000_ffff_0000, 64'h0000_ffff_0000_ffff);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      in_idle_on  = (p != 2);
      out_idle_on = (p != 2 && p != 5);
      if (p == 0) begin
        add_cfg(CFG_GUID_HIGH, '0);
        add_cfg(CFG_GUID_LOW, '0);
        add_cfg(CFG_SYSTEM_TIME, '0);
      end else if (p == RANDOM_PHASES - 1) begin
        add_cfg(CFG_SYSTEM_TIME, '1);
        add_cfg(CFG_GUID_LOW, '1);
        add_cfg(CFG_GUID_HIGH, '1);
      end else begin
        if ($urandom_range(0, 4) != 0) add_cfg(CFG_GUID_HIGH, rand_field());
        if ($urandom_range(0, 4) != 0) add_cfg(CFG_GUID_LOW, rand_field());
        if ($urandom_range(0, 2) == 0) add_cfg(CFG_IDX_UNMAPPED, rand_field());
        if ($urandom_range(0, 4) != 0) add_cfg(CFG_SYSTEM_TIME, rand_field());
      end
      wait_drained();
      for (int k = 0; k < ITEMS_PER_PHASE; k++) add_event(rand_field(), rand_field());
      wait_drained();
    end

    // Let the block settle so any stray result beat is still caught.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pidsha_pkg.sv
hdl/pidsha_ctrl.sv
hdl/pidsha_dp.sv
hdl/process_id_sha256_uuidv8.sv
test/tb_process_id_sha256_uuidv8.sv
